/* hdl/isq_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// isq_pkg: shared definitions for the indexed sequence queue
// Action and status codes, sequencer states, field widths and the
// default sizing of the entry memory.
// ----------------------------------------------------------------------------
package isq_pkg;

	// Default sizing
	localparam int unsigned CAPACITY_DEF   = 16;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Fixed field widths of the stream payloads
	localparam int unsigned ACTION_W   = 3;
	localparam int unsigned POS_W      = 5;
	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned FPOS_W     = 4;
	localparam int unsigned LENGTH_W   = 5;
	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 48;

	// Action codes carried in the input tuser
	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND   = 3'd0,
		ACT_INSERT   = 3'd1,
		ACT_REM_HEAD = 3'd2,
		ACT_REM_POS  = 3'd3,
		ACT_SEARCH   = 3'd4,
		ACT_CLEAR    = 3'd5
	} action_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_BAD_POS = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PUT,
		S_TAKE,
		S_SHIFT_DN,
		S_SEARCH,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

/* hdl/indexed_sequence_queue_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_queue_core: bounded ordered word store
// Append, insert at a position, remove the head or at a position, search
// for the first equal word and clear, on words held in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | signals                     | contents
//  --------+-----+-----------------------------+------------------------------
//  s       | in  | s_tvalid s_tready s_tdata   | tuser action, tdata pos/value
//          |     | s_tuser                     |
//  m       | out | m_tvalid m_tready m_tdata   | status, removed word, found,
//          |     |                             | found position, length
//
//  One transaction at a time. Append, clear, errors and insert at the tail
//  go through S_DONE to the output register; insert at p walks from the tail
//  down to p, remove at p walks from p to the tail, search walks from the
//  head to the first match, paced by the one read and one write port, one entry a step.
//  Reset empties the store at once; the RAM itself is not cleared.
//  A result waits in the output register while the next transaction is
//  taken; a stalled output holds the sequencer only when a new result is due.
// ----------------------------------------------------------------------------
module indexed_sequence_queue_core #(
	parameter int unsigned CAPACITY   = isq_pkg::CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = isq_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// [4:0] position, [36:5] value, [39:37] zero
	input  wire logic [isq_pkg::IN_DATA_W-1:0]   s_tdata,
	// [2:0] action
	input  wire logic [isq_pkg::ACTION_W-1:0]    s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [1:0] status, [33:2] removed_value, [34] found, [38:35] found_position,
	// [43:39] length, [47:44] zero
	output logic [isq_pkg::OUT_DATA_W-1:0]       m_tdata
);

	localparam int unsigned AW   = $clog2(CAPACITY);
	localparam int unsigned CW   = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW = (CW > isq_pkg::POS_W) ? CW : isq_pkg::POS_W;

	// Entry RAM
	logic [DATA_WIDTH-1:0] mem [CAPACITY];
	logic                  mem_re;
	logic [AW-1:0]         mem_ra;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [DATA_WIDTH-1:0] mem_wd;
	logic [DATA_WIDTH-1:0] rd_data_q;

	// Control state
	isq_pkg::state_t state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic            m_tvalid_q, m_tvalid_d;

	// Working registers
	logic [AW-1:0]                  rp_q, rp_d;
	logic [AW-1:0]                  pos_q, pos_d;
	logic [DATA_WIDTH-1:0]          word_q, word_d;
	isq_pkg::status_t               status_q, status_d;
	logic [isq_pkg::VALUE_W-1:0]    removed_q, removed_d;
	logic                           found_q, found_d;
	logic [isq_pkg::FPOS_W-1:0]     fpos_q, fpos_d;
	logic [isq_pkg::OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;

	// Input decode and width adaptation
	logic [isq_pkg::POS_W-1:0]            in_pos;
	logic [isq_pkg::VALUE_W-1:0]          in_value;
	logic [DATA_WIDTH+isq_pkg::VALUE_W-1:0] value_x;
	logic [DATA_WIDTH-1:0]                in_word;
	logic [DATA_WIDTH+isq_pkg::VALUE_W-1:0] rd_x;
	logic [AW+isq_pkg::FPOS_W-1:0]        rp_x;
	logic [CW+isq_pkg::LENGTH_W-1:0]      count_x;
	logic [CMPW-1:0]                      pos_ext;
	logic [CMPW-1:0]                      count_ext;
	logic                                 full;
	logic                                 empty;
	logic [CW-1:0]                        next_rp;
	logic                                 more;

	assign in_pos    = s_tdata[isq_pkg::POS_W-1:0];
	assign in_value  = s_tdata[isq_pkg::POS_W +: isq_pkg::VALUE_W];
	assign value_x   = {{DATA_WIDTH{1'b0}}, in_value};
	assign in_word   = value_x[DATA_WIDTH-1:0];
	assign rd_x      = {{isq_pkg::VALUE_W{1'b0}}, rd_data_q};
	assign rp_x      = {{isq_pkg::FPOS_W{1'b0}}, rp_q};
	assign count_x   = {{isq_pkg::LENGTH_W{1'b0}}, count_q};
	assign pos_ext   = CMPW'(in_pos);
	assign count_ext = CMPW'(count_q);
	assign full      = (count_q == CW'(CAPACITY));
	assign empty     = (count_q == '0);
	assign next_rp   = CW'(rp_q) + CW'(1);
	assign more      = (next_rp < count_q);

	assign s_tready = (state_q == isq_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Sequencer: next state, RAM accesses and result fields
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		m_tvalid_d = m_tvalid_q & ~m_tready;
		m_tdata_d  = m_tdata_q;
		rp_d       = rp_q;
		pos_d      = pos_q;
		word_d     = word_q;
		status_d   = status_q;
		removed_d  = removed_q;
		found_d    = found_q;
		fpos_d     = fpos_q;
		mem_re     = 1'b0;
		mem_ra     = rp_q;
		mem_we     = 1'b0;
		mem_wa     = rp_q;
		mem_wd     = rd_data_q;
		unique case (state_q)
			isq_pkg::S_IDLE: begin
				if (s_tvalid) begin
					word_d    = in_word;
					pos_d     = AW'(pos_ext);
					status_d  = isq_pkg::ST_OK;
					removed_d = '0;
					found_d   = 1'b0;
					fpos_d    = '0;
					state_d   = isq_pkg::S_DONE;
					unique case (s_tuser)
						isq_pkg::ACT_APPEND: begin
							if (full) begin
								status_d = isq_pkg::ST_FULL;
							end else begin
								mem_we  = 1'b1;
								mem_wa  = AW'(count_q);
								mem_wd  = in_word;
								count_d = count_q + CW'(1);
							end
						end
						isq_pkg::ACT_INSERT: begin
							if (pos_ext > count_ext) begin
								status_d = isq_pkg::ST_BAD_POS;
							end else if (full) begin
								status_d = isq_pkg::ST_FULL;
							end else if (pos_ext == count_ext) begin
								mem_we  = 1'b1;
								mem_wa  = AW'(count_q);
								mem_wd  = in_word;
								count_d = count_q + CW'(1);
							end else begin
								// open a gap: walk from the tail down to the position
								mem_re  = 1'b1;
								mem_ra  = AW'(count_q - CW'(1));
								rp_d    = AW'(count_q - CW'(1));
								state_d = isq_pkg::S_SHIFT_UP;
							end
						end
						isq_pkg::ACT_REM_HEAD: begin
							if (empty) begin
								status_d = isq_pkg::ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								mem_ra  = '0;
								rp_d    = '0;
								pos_d   = '0;
								state_d = isq_pkg::S_TAKE;
							end
						end
						isq_pkg::ACT_REM_POS: begin
							if (empty) begin
								status_d = isq_pkg::ST_EMPTY;
							end else if (pos_ext >= count_ext) begin
								status_d = isq_pkg::ST_BAD_POS;
							end else begin
								mem_re  = 1'b1;
								mem_ra  = AW'(pos_ext);
								rp_d    = AW'(pos_ext);
								state_d = isq_pkg::S_TAKE;
							end
						end
						isq_pkg::ACT_SEARCH: begin
							if (!empty) begin
								mem_re  = 1'b1;
								mem_ra  = '0;
								rp_d    = '0;
								state_d = isq_pkg::S_SEARCH;
							end
						end
						isq_pkg::ACT_CLEAR: begin
							count_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			isq_pkg::S_SHIFT_UP: begin
				// move the entry read last cycle one place toward the tail
				mem_we = 1'b1;
				mem_wa = rp_q + AW'(1);
				mem_wd = rd_data_q;
				if (rp_q == pos_q) begin
					state_d = isq_pkg::S_PUT;
				end else begin
					mem_re = 1'b1;
					mem_ra = rp_q - AW'(1);
					rp_d   = rp_q - AW'(1);
				end
			end
			isq_pkg::S_PUT: begin
				mem_we  = 1'b1;
				mem_wa  = pos_q;
				mem_wd  = word_q;
				count_d = count_q + CW'(1);
				state_d = isq_pkg::S_DONE;
			end
			isq_pkg::S_TAKE, isq_pkg::S_SHIFT_DN: begin
				if (state_q == isq_pkg::S_TAKE) begin
					removed_d = rd_x[isq_pkg::VALUE_W-1:0];
				end else begin
					// close the gap: move the entry one place toward the head
					mem_we = 1'b1;
					mem_wa = rp_q - AW'(1);
					mem_wd = rd_data_q;
				end
				if (more) begin
					mem_re  = 1'b1;
					mem_ra  = AW'(next_rp);
					rp_d    = AW'(next_rp);
					state_d = isq_pkg::S_SHIFT_DN;
				end else begin
					count_d = count_q - CW'(1);
					state_d = isq_pkg::S_DONE;
				end
			end
			isq_pkg::S_SEARCH: begin
				if (rd_data_q == word_q) begin
					found_d = 1'b1;
					fpos_d  = rp_x[isq_pkg::FPOS_W-1:0];
					state_d = isq_pkg::S_DONE;
				end else if (more) begin
					mem_re = 1'b1;
					mem_ra = AW'(next_rp);
					rp_d   = AW'(next_rp);
				end else begin
					state_d = isq_pkg::S_DONE;
				end
			end
			isq_pkg::S_DONE: begin
				// load the output register once it is free
				if (!m_tvalid_q || m_tready) begin
					m_tdata_d  = {4'b0000, count_x[isq_pkg::LENGTH_W-1:0], fpos_q,
						found_q, removed_q, status_q};
					m_tvalid_d = 1'b1;
					state_d    = isq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = isq_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= isq_pkg::S_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		rp_q      <= rp_d;
		pos_q     <= pos_d;
		word_q    <= word_d;
		status_q  <= status_d;
		removed_q <= removed_d;
		found_q   <= found_d;
		fpos_q    <= fpos_d;
		m_tdata_q <= m_tdata_d;
	end

	// Entry RAM: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_wa) < CW'(CAPACITY)))
		else $error("entry RAM written outside its depth");

	a_walk_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isq_pkg::S_SHIFT_UP || state_q == isq_pkg::S_TAKE ||
		 state_q == isq_pkg::S_SHIFT_DN || state_q == isq_pkg::S_SEARCH)
		|-> (CW'(rp_q) < count_q))
		else $error("walk pointer beyond the stored entries");

	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isq_pkg::S_SHIFT_UP || state_q == isq_pkg::S_SHIFT_DN ||
		 state_q == isq_pkg::S_SEARCH || state_q == isq_pkg::S_TAKE)
		|-> $past(mem_re))
		else $error("walk step without a read issued the cycle before");
`endif

endmodule
`default_nettype wire

/* dv/isq_stream_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// isq_stream_checker: result checker for the indexed sequence queue
// Watches both stream channels of the core. Every input transaction is run
// through a behavioral copy of the word store, and the predicted result is
// queued. Every output transaction is compared field by field with the
// oldest queued prediction. The mismatch count and the number of results
// still due are handed to the testbench top.
// ----------------------------------------------------------------------------
module isq_stream_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	input  wire logic                           s_tready,
	// [4:0] position, [36:5] value, [39:37] zero
	input  wire logic [isq_pkg::IN_DATA_W-1:0]  s_tdata,
	// [2:0] action
	input  wire logic [isq_pkg::ACTION_W-1:0]   s_tuser,
	input  wire logic                           m_tvalid,
	input  wire logic                           m_tready,
	// [1:0] status, [33:2] removed_value, [34] found, [38:35] found_position,
	// [43:39] length, [47:44] zero
	input  wire logic [isq_pkg::OUT_DATA_W-1:0] m_tdata,
	output int unsigned                         error_count,
	output int unsigned                         results_due
);

	localparam int unsigned DEPTH     = isq_pkg::CAPACITY_DEF;
	localparam int unsigned VAL_W     = isq_pkg::VALUE_W;
	localparam int unsigned REM_LSB   = isq_pkg::STATUS_W;
	localparam int unsigned FOUND_BIT = REM_LSB + VAL_W;
	localparam int unsigned FPOS_LSB  = FOUND_BIT + 1;
	localparam int unsigned LEN_LSB   = FPOS_LSB + isq_pkg::FPOS_W;

	typedef struct packed {
		isq_pkg::status_t               status;
		logic [VAL_W-1:0]               removed_value;
		logic                           found;
		logic [isq_pkg::FPOS_W-1:0]     found_position;
		logic [isq_pkg::LENGTH_W-1:0]   length;
	} queue_result_t;

	// Shadow copy of the word store
	logic [isq_pkg::DATA_WIDTH_DEF-1:0] shadow_words [DEPTH];
	int unsigned                        shadow_length;
	queue_result_t                      pending_results [$];

	// Apply one action to the shadow store and return the result it gives.
	function automatic queue_result_t queue_apply_action(
		input logic [isq_pkg::ACTION_W-1:0] act,
		input int unsigned                  pos,
		input logic [VAL_W-1:0]             word
	);
		queue_result_t res;
		int unsigned   i;
		res = '0;
		case (act)
			isq_pkg::ACT_APPEND: begin
				if (shadow_length >= DEPTH) begin
					res.status = isq_pkg::ST_FULL;
				end else begin
					shadow_words[shadow_length] = word;
					shadow_length++;
				end
			end
			isq_pkg::ACT_INSERT: begin
				if (pos > shadow_length) begin
					res.status = isq_pkg::ST_BAD_POS;
				end else if (shadow_length >= DEPTH) begin
					res.status = isq_pkg::ST_FULL;
				end else begin
					for (i = shadow_length; i > pos; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[pos] = word;
					shadow_length++;
				end
			end
			isq_pkg::ACT_REM_HEAD, isq_pkg::ACT_REM_POS: begin
				// emptiness is checked before the position
				i = (act == isq_pkg::ACT_REM_HEAD) ? 0 : pos;
				if (shadow_length == 0) begin
					res.status = isq_pkg::ST_EMPTY;
				end else if (i >= shadow_length) begin
					res.status = isq_pkg::ST_BAD_POS;
				end else begin
					res.removed_value = shadow_words[i];
					while (i + 1 < shadow_length) begin
						shadow_words[i] = shadow_words[i+1];
						i++;
					end
					shadow_length--;
				end
			end
			isq_pkg::ACT_SEARCH: begin
				// report the first equal word only
				for (i = 0; i < shadow_length; i++) begin
					if (!res.found && shadow_words[i] == word) begin
						res.found          = 1'b1;
						res.found_position = isq_pkg::FPOS_W'(i);
					end
				end
			end
			isq_pkg::ACT_CLEAR: begin
				shadow_length = 0;
			end
			default: begin
			end
		endcase
		res.length = isq_pkg::LENGTH_W'(shadow_length);
		return res;
	endfunction

	// Count and report one field that differs from its prediction.
	task automatic check_field(
		input string            field,
		input logic [VAL_W-1:0] want,
		input logic [VAL_W-1:0] got
	);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	// Compare output transactions first, then queue the prediction of the input
	always @(posedge clk or negedge arst_n) begin : watch_channels
		queue_result_t want;
		if (!arst_n) begin
			pending_results.delete();
			shadow_length = 0;
			error_count   = 0;
			results_due   = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, m_tdata);
				end else begin
					want = pending_results.pop_front();
					check_field("status", VAL_W'(want.status),
						VAL_W'(m_tdata[isq_pkg::STATUS_W-1:0]));
					check_field("removed_value", want.removed_value,
						m_tdata[REM_LSB +: VAL_W]);
					check_field("found", VAL_W'(want.found), VAL_W'(m_tdata[FOUND_BIT]));
					check_field("found_position", VAL_W'(want.found_position),
						VAL_W'(m_tdata[FPOS_LSB +: isq_pkg::FPOS_W]));
					check_field("length", VAL_W'(want.length),
						VAL_W'(m_tdata[LEN_LSB +: isq_pkg::LENGTH_W]));
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(queue_apply_action(s_tuser,
					32'(s_tdata[isq_pkg::POS_W-1:0]),
					s_tdata[isq_pkg::POS_W +: VAL_W]));
			results_due = pending_results.size();
		end
	end

endmodule

/* dv/tb_indexed_sequence_queue_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_sequence_queue_core: testbench for the indexed sequence queue
// Drives a directed pass over empty, full and bad position cases, then
// random growing and shrinking phases of actions in bursts, against a
// receiver that stalls in changing patterns. A separate checker predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_queue_core;

	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned QUIET_LIMIT  = 2000;
	localparam int unsigned TAIL_CYCLES  = 2 * isq_pkg::CAPACITY_DEF + 8;
	localparam int unsigned FULL_POS     = isq_pkg::CAPACITY_DEF;
	localparam int unsigned ACT_W        = isq_pkg::ACTION_W;
	localparam int unsigned P_W          = isq_pkg::POS_W;
	localparam int unsigned VAL_W        = isq_pkg::VALUE_W;

	// Action codes the core takes but ignores
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_PERIODIC,
		RDY_SPARSE
	} ready_mode_t;

	logic                               clk;
	logic                               arst_n;
	logic                               s_tvalid;
	logic                               s_tready;
	// [4:0] position, [36:5] value, [39:37] zero
	logic [isq_pkg::IN_DATA_W-1:0]      s_tdata;
	// [2:0] action
	logic [ACT_W-1:0]                   s_tuser;
	logic                               m_tvalid;
	logic                               m_tready;
	// [1:0] status, [33:2] removed_value, [34] found, [38:35] found_position,
	// [43:39] length, [47:44] zero
	logic [isq_pkg::OUT_DATA_W-1:0]     m_tdata;
	int unsigned                        error_count;
	int unsigned                        results_due;

	logic [VAL_W-1:0]                   recent_words [8];
	int unsigned                        recent_wr;
	int unsigned                        burst_left;

	indexed_sequence_queue_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	isq_stream_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.error_count (error_count),
		.results_due (results_due)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stall the receiver in spans of changing patterns
	initial begin : ready_pattern
		ready_mode_t mode;
		int unsigned phase;
		int unsigned period;
		m_tready = 1'b0;
		phase    = 0;
		forever begin
			mode   = ready_mode_t'($urandom_range(0, 3));
			period = $urandom_range(2, 12);
			repeat ($urandom_range(32, 256)) begin
				@(negedge clk);
				phase++;
				case (mode)
					RDY_ALWAYS:   m_tready <= 1'b1;
					RDY_COIN:     m_tready <= ($urandom_range(0, 1) == 1);
					RDY_PERIODIC: m_tready <= ((phase % period) == 0);
					default:      m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Present one transaction and hold it until the core takes it.
	task automatic push_action(
		input logic [ACT_W-1:0] act,
		input logic [P_W-1:0]   pos,
		input logic [VAL_W-1:0] word
	);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {3'b000, word, pos};
		do @(posedge clk); while (!s_tready);
	endtask

	// Drop valid for a number of cycles, with noise on the payload.
	task automatic idle_sender(input int unsigned cycles);
		if (cycles != 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tuser  <= ACT_W'($urandom_range(0, 7));
			s_tdata  <= {3'b000, $urandom(), P_W'($urandom_range(0, 31))};
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Send one transaction inside a burst; when the burst ends, insert a gap of random length, possibly none.
	task automatic issue_action(
		input logic [ACT_W-1:0] act,
		input logic [P_W-1:0]   pos,
		input logic [VAL_W-1:0] word
	);
		push_action(act, pos, word);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
			burst_left = $urandom_range(0, 23);
		end
	endtask

	// Hold off the sender until every result has come back.
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
	endtask

	// Pick a word: recent inserts and small values make search hits and duplicates.
	function automatic logic [VAL_W-1:0] pick_word();
		case ($urandom_range(0, 3))
			0:       return recent_words[$urandom_range(0, 7)];
			1:       return VAL_W'($urandom_range(0, 7));
			2:       return ($urandom_range(0, 1) == 1) ? {VAL_W{1'b1}} : '0;
			default: return $urandom();
		endcase
	endfunction

	// Draw one random action, weighted toward growing or shrinking the store.
	task automatic random_item(input bit grow);
		logic [ACT_W-1:0] act;
		logic [P_W-1:0]   pos;
		logic [VAL_W-1:0] word;
		int unsigned      roll;
		word = pick_word();
		roll = $urandom_range(0, 99);
		if (roll < 8)
			pos = P_W'($urandom_range(FULL_POS + 1, 31));
		else if (grow)
			pos = P_W'($urandom_range(0, FULL_POS));
		else
			pos = P_W'($urandom_range(0, $urandom_range(0, FULL_POS)));
		roll = $urandom_range(0, 99);
		if (grow) begin
			if (roll < 35)      act = isq_pkg::ACT_APPEND;
			else if (roll < 65) act = isq_pkg::ACT_INSERT;
			else if (roll < 75) act = isq_pkg::ACT_REM_HEAD;
			else if (roll < 83) act = isq_pkg::ACT_REM_POS;
			else if (roll < 96) act = isq_pkg::ACT_SEARCH;
			else if (roll < 98) act = isq_pkg::ACT_CLEAR;
			else                act = ($urandom_range(0, 1) == 1) ? ACT_SPARE_A : ACT_SPARE_B;
		end else begin
			if (roll < 10)      act = isq_pkg::ACT_APPEND;
			else if (roll < 20) act = isq_pkg::ACT_INSERT;
			else if (roll < 50) act = isq_pkg::ACT_REM_HEAD;
			else if (roll < 75) act = isq_pkg::ACT_REM_POS;
			else if (roll < 94) act = isq_pkg::ACT_SEARCH;
			else if (roll < 97) act = isq_pkg::ACT_CLEAR;
			else                act = ($urandom_range(0, 1) == 1) ? ACT_SPARE_A : ACT_SPARE_B;
		end
		if (act == isq_pkg::ACT_APPEND || act == isq_pkg::ACT_INSERT) begin
			recent_words[recent_wr % 8] = word;
			recent_wr++;
		end
		issue_action(act, pos, word);
	endtask

	// Reset, directed cases, random phases, then verdict
	initial begin : stimulus
		int unsigned n;
		int unsigned phase_left;
		bit          grow;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = isq_pkg::ACT_APPEND;
		recent_wr  = 0;
		burst_left = 0;
		grow       = 1'b1;
		phase_left = 0;
		for (n = 0; n < 8; n++)
			recent_words[n] = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty store: search, both removals, insert past the length, spare code
		issue_action(isq_pkg::ACT_SEARCH, '0, {VAL_W{1'b1}});
		issue_action(isq_pkg::ACT_REM_HEAD, '0, '0);
		issue_action(isq_pkg::ACT_REM_POS, '1, '0);
		issue_action(isq_pkg::ACT_INSERT, 5'd1, $urandom());
		issue_action(ACT_SPARE_A, '0, '0);

		// Fill to capacity by inserts at the head, in the middle and appends
		issue_action(isq_pkg::ACT_INSERT, '0, '0);
		for (n = 1; n < isq_pkg::CAPACITY_DEF - 1; n++) begin
			if (n % 3 == 1)      issue_action(isq_pkg::ACT_INSERT, '0, $urandom());
			else if (n % 3 == 2) issue_action(isq_pkg::ACT_APPEND, '0, $urandom());
			else                 issue_action(isq_pkg::ACT_INSERT, P_W'(n / 2), $urandom());
		end
		issue_action(isq_pkg::ACT_APPEND, '0, {VAL_W{1'b1}});

		// Full store: overflow, bad positions, search and removal at both ends
		issue_action(isq_pkg::ACT_APPEND, '0, $urandom());
		issue_action(isq_pkg::ACT_INSERT, P_W'(FULL_POS), $urandom());
		issue_action(isq_pkg::ACT_INSERT, P_W'(FULL_POS + 1), $urandom());
		issue_action(isq_pkg::ACT_REM_POS, P_W'(FULL_POS), '0);
		issue_action(isq_pkg::ACT_SEARCH, '0, {VAL_W{1'b1}});
		issue_action(isq_pkg::ACT_REM_POS, P_W'(FULL_POS - 1), '0);
		issue_action(isq_pkg::ACT_REM_POS, '0, '0);
		issue_action(ACT_SPARE_B, '1, '1);
		issue_action(isq_pkg::ACT_CLEAR, '0, '0);
		wait_drained();

		// Random phases; drain at every phase change
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				wait_drained();
				grow       = ~grow;
				phase_left = $urandom_range(60, 300);
			end
			phase_left--;
			random_item(grow);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0 && results_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
